### rtl/segmented_message_deframer_assert.svh
// ----------------------------------------------------------------------------
// Segmented message deframer assertion macros
// Concurrent check macros clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_MESSAGE_DEFRAMER_ASSERT_SVH
`define SEGMENTED_MESSAGE_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define SMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMD_ASSERT_IMP(lbl, ante, cons, msg)
`define SMD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types, state codes and helpers of the segmented message deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smd_pkg;

  localparam int unsigned NumLanes = 4;

  localparam logic [2:0] StHunt    = 3'd0;
  localparam logic [2:0] StHeader  = 3'd1;
  localparam logic [2:0] StPayload = 3'd2;
  localparam logic [2:0] StEos     = 3'd3;
  localparam logic [2:0] StEom     = 3'd4;

  localparam logic [1:0] RegPreamble  = 2'd0;
  localparam logic [1:0] RegPostamble = 2'd1;
  localparam logic [1:0] RegMaxBytes  = 2'd2;

  localparam logic [31:0] PreambleReset  = 32'h1616_1616;
  localparam logic [31:0] PostambleReset = 32'h1717_1717;
  localparam logic [7:0]  MaxBytesReset  = 8'd47;

  typedef struct packed {
    logic pre;
    logic post;
  } lane_hit_t;

  typedef struct packed {
    logic       found;
    logic       is_pre;
    logic [2:0] offset;
  } match_t;

  typedef struct packed {
    logic [31:0] payload_bytes;
    logic [2:0]  byte_count;
    logic        message_start;
    logic        segment_done;
    logic        message_done;
    logic [2:0]  parse_state;
  } result_t;

  function automatic logic [7:0] win_byte(input logic [63:0] win, input logic [2:0] pos);
    return win[{pos, 3'b000} +: 8];
  endfunction

endpackage

### rtl/segmented_message_deframer.sv
// Marker search runs in four parallel compare lanes; results go to the output buffer.
// Throughput: one beat per cycle while the output buffer is not full.
// A two-entry output buffer keeps input ready high while one result waits downstream.
// Reset (rst_ni, asynchronous, active low) clears the parser state and empties the buffer.
// Reset also restores the marker words and the length limit to their default values.
// ----------------------------------------------------------------------------
// segmented_message_deframer
// Aligns framed segments in a 32-bit word stream and emits their payload bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segmented_message_deframer_assert.svh"

module segmented_message_deframer import smd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] payload_bytes_o,
  output logic [2:0]  byte_count_o,
  output logic        message_start_o,
  output logic        segment_done_o,
  output logic        message_done_o,
  output logic [2:0]  parse_state_o
);

  logic [31:0] preamble_q;
  logic [31:0] postamble_q;
  logic [7:0]  max_bytes_q;
  logic        step;
  result_t     result;
  result_t     out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q  <= PreambleReset;
      postamble_q <= PostambleReset;
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPreamble:  preamble_q  <= cfg_wdata_i;
        RegPostamble: postamble_q <= cfg_wdata_i;
        RegMaxBytes:  max_bytes_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign step = in_valid_i && in_ready_o;

  smd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_word_i (data_word_i),
    .preamble_i  (preamble_q),
    .postamble_i (postamble_q),
    .max_bytes_i (max_bytes_q),
    .result_o    (result)
  );

  smd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (result),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data)
  );

  assign payload_bytes_o = out_data.payload_bytes;
  assign byte_count_o    = out_data.byte_count;
  assign message_start_o = out_data.message_start;
  assign segment_done_o  = out_data.segment_done;
  assign message_done_o  = out_data.message_done;
  assign parse_state_o   = out_data.parse_state;

  `SMD_ASSERT_IMP(a_full_has_output, !in_ready_o, out_valid_o, "buffer full without output")
  `SMD_ASSERT_IMP(a_msg_done_state, out_valid_o && message_done_o, parse_state_o == StEom,
                  "message done outside end of message")
  `SMD_ASSERT_IMP(a_seg_done_state, out_valid_o && segment_done_o, parse_state_o == StEos,
                  "segment done outside end of segment")
  `SMD_ASSERT_IMP(a_start_no_data, out_valid_o && message_start_o,
                  byte_count_o == 3'd0 && parse_state_o == StPayload,
                  "message start carries payload or wrong state")
  `SMD_ASSERT_NXT(a_accept_gives_output, in_valid_i && in_ready_o, out_valid_o,
                  "accepted beat produced no output")

endmodule

### rtl/smd_lane.sv
// ----------------------------------------------------------------------------
// smd_lane
// Compares one window alignment against the start and end markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_lane import smd_pkg::*; (
  input  logic [31:0] word_i,
  input  logic [31:0] preamble_i,
  input  logic [31:0] postamble_i,
  output lane_hit_t   hit_o
);

  assign hit_o.pre  = (word_i == preamble_i);
  assign hit_o.post = (word_i == postamble_i);

endmodule

### rtl/smd_merge.sv
// ----------------------------------------------------------------------------
// smd_merge
// Picks the highest-offset lane that hit; the start marker wins within a lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_merge import smd_pkg::*; (
  input  lane_hit_t [NumLanes-1:0] hits_i,
  output match_t                   match_o
);

  always_comb begin
    match_o = '0;
    for (int g = NumLanes - 1; g >= 0; g--) begin
      if (!match_o.found && (hits_i[g].pre || hits_i[g].post)) begin
        match_o.found  = 1'b1;
        match_o.is_pre = hits_i[g].pre;
        match_o.offset = 3'(g + 1);
      end
    end
  end

endmodule

### rtl/smd_outbuf.sv
// ----------------------------------------------------------------------------
// smd_outbuf
// Two-entry output buffer so a new beat is taken while a result is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_outbuf import smd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    main_valid_q, main_valid_d;
  logic    spare_valid_q, spare_valid_d;
  result_t main_q, main_d;
  result_t spare_q, spare_d;
  logic    pop;

  assign pop     = main_valid_q && ready_i;
  assign ready_o = !spare_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_comb begin
    main_valid_d  = main_valid_q;
    spare_valid_d = spare_valid_q;
    main_d        = main_q;
    spare_d       = spare_q;
    if (!main_valid_q || pop) begin
      if (spare_valid_q) begin
        main_d        = spare_q;
        main_valid_d  = 1'b1;
        spare_valid_d = push_i;
        spare_d       = push_data_i;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      spare_valid_d = 1'b1;
      spare_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q  <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      main_valid_q  <= main_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q  <= main_d;
    spare_q <= spare_d;
  end

endmodule

### rtl/smd_parser.sv
// ----------------------------------------------------------------------------
// smd_parser
// Window, marker lanes and frame state machine; one result per input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_parser import smd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [31:0] data_word_i,
  input  logic [31:0] preamble_i,
  input  logic [31:0] postamble_i,
  input  logic [7:0]  max_bytes_i,
  output result_t     result_o
);

  typedef enum logic [2:0] {
    S_HUNT    = StHunt,
    S_HEADER  = StHeader,
    S_PAYLOAD = StPayload,
    S_EOS     = StEos,
    S_EOM     = StEom
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] prev_word_q;
  logic [2:0]  align_q, align_d;
  logic [7:0]  left_q, left_d;
  logic        last_q, last_d;
  logic [6:0]  seq_q, seq_d;

  logic [63:0]               window;
  lane_hit_t [NumLanes-1:0]  hits;
  match_t                    match;

  logic [7:0] hdr_byte;
  logic [7:0] len_raw;
  logic [7:0] len;
  logic [2:0] count;

  assign window = {data_word_i, prev_word_q};

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    smd_lane u_lane (
      .word_i      (window[(g + 1) * 8 +: 32]),
      .preamble_i  (preamble_i),
      .postamble_i (postamble_i),
      .hit_o       (hits[g])
    );
  end

  smd_merge u_merge (
    .hits_i  (hits),
    .match_o (match)
  );

  assign hdr_byte = win_byte(window, align_q + 3'd2);
  assign len_raw  = win_byte(window, align_q + 3'd3);
  assign len      = (len_raw > max_bytes_i) ? max_bytes_i : len_raw;
  assign count    = (left_q < 8'd4) ? left_q[2:0] : 3'd4;

  always_comb begin
    state_d  = state_q;
    align_d  = align_q;
    left_d   = left_q;
    last_d   = last_q;
    seq_d    = seq_q;
    result_o = '0;
    if (match.found) begin
      if (match.is_pre) begin
        align_d = match.offset;
        state_d = S_HEADER;
      end else begin
        state_d = S_HUNT;
        left_d  = '0;
      end
    end else begin
      case (state_q)
        S_HEADER: begin
          last_d = hdr_byte[7];
          if (len == 8'd0) begin
            state_d = S_HUNT;
            left_d  = '0;
          end else if (hdr_byte[6:0] == 7'd0) begin
            result_o.message_start = 1'b1;
            seq_d   = '0;
            left_d  = len;
            state_d = S_PAYLOAD;
          end else if ({1'b0, hdr_byte[6:0]} == ({1'b0, seq_q} + 8'd1)) begin
            seq_d   = hdr_byte[6:0];
            left_d  = len;
            state_d = S_PAYLOAD;
          end else begin
            state_d = S_HUNT;
            left_d  = '0;
          end
        end
        S_PAYLOAD: begin
          result_o.byte_count = count;
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < count) begin
              result_o.payload_bytes[i * 8 +: 8] = win_byte(window, align_q + 3'(i));
            end
          end
          left_d = left_q - {5'd0, count};
          if (left_d == 8'd0) begin
            if (last_q) begin
              state_d = S_EOM;
              result_o.message_done = 1'b1;
            end else begin
              state_d = S_EOS;
              result_o.segment_done = 1'b1;
            end
          end
        end
        default: begin
          state_d = S_HUNT;
          left_d  = '0;
        end
      endcase
    end
    result_o.parse_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HUNT;
      prev_word_q <= '0;
      align_q     <= '0;
      left_q      <= '0;
      last_q      <= 1'b0;
      seq_q       <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      prev_word_q <= data_word_i;
      align_q     <= align_d;
      left_q      <= left_d;
      last_q      <= last_d;
      seq_q       <= seq_d;
    end
  end

endmodule
